>>> rtl/core/gta_pkg.sv
// types, constants and the slice dot product shared by the gemm tile accumulator
`timescale 1ns / 1ps

package gta_pkg;

  localparam int TILE_ROWS   = 16;
  localparam int DEPTH_BLOCK = 8;
  localparam int TILE_COLS   = 4;
  localparam int ROW_AW      = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int DOT_W       = 19;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCUMULATE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_COLS      = 2'd1;

  typedef struct packed {
    logic [3:0]         row;
    logic [63:0]        a_chunk;
    logic [63:0]        b_col0;
    logic [63:0]        b_col1;
    logic [63:0]        b_col2;
    logic [63:0]        b_col3;
    logic               first_block;
    logic               last_block;
    logic signed [31:0] prior0;
    logic signed [31:0] prior1;
    logic signed [31:0] prior2;
    logic signed [31:0] prior3;
  } in_t;

  typedef struct packed {
    logic [3:0]         out_row;
    logic signed [31:0] sum0;
    logic signed [31:0] sum1;
    logic signed [31:0] sum2;
    logic signed [31:0] sum3;
  } out_t;

  typedef logic [TILE_COLS-1:0][31:0]           row_sums_t;
  typedef logic signed [TILE_COLS-1:0][DOT_W-1:0] row_dots_t;

  function automatic logic signed [DOT_W-1:0] dot8(input logic [63:0] a,
                                                   input logic [63:0] b);
    logic signed [DOT_W-1:0] s;
    logic signed [7:0]       ai;
    logic signed [7:0]       bi;
    logic signed [15:0]      p;
    s = '0;
    for (int i = 0; i < DEPTH_BLOCK; i++) begin
      ai = a[8*i +: 8];
      bi = b[8*i +: 8];
      p  = ai * bi;
      s  = s + DOT_W'(p);
    end
    return s;
  endfunction

endpackage

>>> rtl/core/int8_gemm_tile_accumulator.sv
// int8 gemm tile accumulator: 16x4 tile of 32-bit sums fed by 8-deep slices
// a result follows its last slice through input, dot and result registers
// throughput: one slice per cycle, any row order, while results leave on out_ready
// stages: input register, dot product register with row read, result register
// reset clears pipeline valids, accumulate_mode to 0 and valid_cols to 4
// accumulator rows are undefined until a first slice writes them
`timescale 1ns / 1ps

module int8_gemm_tile_accumulator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gta_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gta_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gta_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // configuration
  logic       acc_mode_r;
  logic [2:0] valid_cols_r;
  logic [gta_pkg::TILE_COLS-1:0] col_en;

  // stage 1
  logic         v1_r;
  gta_pkg::in_t s1_r;

  // stage 2
  logic                        v2_r;
  logic [3:0]                  row2_r;
  logic                        first2_r;
  logic                        last2_r;
  gta_pkg::row_dots_t          dot2_r;
  gta_pkg::row_sums_t          prior2_r;
  gta_pkg::row_dots_t          dot_nxt;
  gta_pkg::row_sums_t          prior_nxt;

  // accumulator memory and bypass of the latest write
  gta_pkg::row_sums_t          mem [gta_pkg::TILE_ROWS];
  gta_pkg::row_sums_t          rd_r;
  logic                        byp_v_r;
  logic [gta_pkg::ROW_AW-1:0]  byp_row_r;
  gta_pkg::row_sums_t          byp_sum_r;
  gta_pkg::row_sums_t          base;
  gta_pkg::row_sums_t          sum_nxt;

  // result register
  logic          out_valid_r;
  gta_pkg::out_t out_data_r;

  logic s1_go;
  logic s2_go;
  logic in_go;
  logic in_row_ok;

  assign s2_go     = v2_r && (!last2_r || !out_valid_r || out_ready);
  assign s1_go     = v1_r && (!v2_r || s2_go);
  assign in_ready  = !v1_r || s1_go;
  assign in_go     = in_valid && in_ready;
  assign in_row_ok = int'(in_data.row) < gta_pkg::TILE_ROWS;
  assign cfg_ready = 1'b1;

  always_comb begin
    for (int c = 0; c < gta_pkg::TILE_COLS; c++) begin
      col_en[c] = valid_cols_r > 3'(c);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_mode_r   <= 1'b0;
      valid_cols_r <= 3'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gta_pkg::CFG_ACCUMULATE_MODE: acc_mode_r   <= cfg_data[0];
        gta_pkg::CFG_VALID_COLS:      valid_cols_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // stage 1: input register, out of range rows dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_ready) begin
      v1_r <= in_go && in_row_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_r <= in_data;
    end
  end

  // stage 1 to 2: dot products and start values
  always_comb begin
    dot_nxt[0] = gta_pkg::dot8(s1_r.a_chunk, s1_r.b_col0);
    dot_nxt[1] = gta_pkg::dot8(s1_r.a_chunk, s1_r.b_col1);
    dot_nxt[2] = gta_pkg::dot8(s1_r.a_chunk, s1_r.b_col2);
    dot_nxt[3] = gta_pkg::dot8(s1_r.a_chunk, s1_r.b_col3);
    prior_nxt[0] = (acc_mode_r && col_en[0]) ? s1_r.prior0 : '0;
    prior_nxt[1] = (acc_mode_r && col_en[1]) ? s1_r.prior1 : '0;
    prior_nxt[2] = (acc_mode_r && col_en[2]) ? s1_r.prior2 : '0;
    prior_nxt[3] = (acc_mode_r && col_en[3]) ? s1_r.prior3 : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (!v2_r || s2_go) begin
      v2_r <= s1_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      row2_r   <= s1_r.row;
      first2_r <= s1_r.first_block;
      last2_r  <= s1_r.last_block;
      dot2_r   <= dot_nxt;
      prior2_r <= prior_nxt;
    end
  end

  // row read on entry to stage 2, row write when stage 2 leaves
  always_ff @(posedge clk) begin
    if (s1_go) begin
      rd_r <= mem[gta_pkg::ROW_AW'(s1_r.row)];
    end
    if (s2_go) begin
      mem[gta_pkg::ROW_AW'(row2_r)] <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_v_r <= 1'b0;
    end else if (s2_go) begin
      byp_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      byp_row_r <= gta_pkg::ROW_AW'(row2_r);
      byp_sum_r <= sum_nxt;
    end
  end

  // stage 2: start value select and accumulate
  always_comb begin
    if (byp_v_r && (byp_row_r == gta_pkg::ROW_AW'(row2_r))) begin
      base = byp_sum_r;
    end else begin
      base = rd_r;
    end
    if (first2_r) begin
      base = prior2_r;
    end
    for (int c = 0; c < gta_pkg::TILE_COLS; c++) begin
      sum_nxt[c] = base[c] + 32'(signed'(dot2_r[c]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go && last2_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && last2_r) begin
      out_data_r.out_row <= row2_r;
      out_data_r.sum0    <= col_en[0] ? sum_nxt[0] : '0;
      out_data_r.sum1    <= col_en[1] ? sum_nxt[1] : '0;
      out_data_r.sum2    <= col_en[2] ? sum_nxt[2] : '0;
      out_data_r.sum3    <= col_en[3] ? sum_nxt[3] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
